>>> rtl/core/pbm_pkg.sv
package pbm_pkg;

    // Largest accepted image width or height.
    localparam int MAX_DIM = 4096;

    // Command queue between the parser and the pixel expander.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Result kinds, also used as queue command codes.
    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_LEAD_SPACE = 3'd1,
        ERR_BAD_MAGIC  = 3'd2,
        ERR_BAD_NUMBER = 3'd3,
        ERR_RANGE      = 3'd4,
        ERR_EARLY_END  = 3'd5
    } err_code_t;

    typedef enum logic [2:0] {
        PH_MAGIC_WAIT = 3'd0,
        PH_MAGIC      = 3'd1,
        PH_W_WAIT     = 3'd2,
        PH_W          = 3'd3,
        PH_H_WAIT     = 3'd4,
        PH_H          = 3'd5,
        PH_DATA       = 3'd6,
        PH_HALT       = 3'd7
    } phase_t;

    // Progress of a decimal size token.
    typedef enum logic [2:0] {
        NS_NONE   = 3'd0,
        NS_DIGITS = 3'd1,
        NS_DONE   = 3'd2,
        NS_OVER   = 3'd3,
        NS_NODIG  = 3'd4
    } num_status_t;

    typedef struct packed {
        num_status_t status;
        logic [12:0] value;
    } num_t;

    // One queued command: a data byte to unpack, a header or an error.
    typedef struct packed {
        kind_t       op;
        logic [7:0]  data;
        logic [11:0] col;
        logic [11:0] row;
        logic [3:0]  count;
        logic        done;
        logic [12:0] wd;
        logic [12:0] ht;
        err_code_t   err;
    } pbm_cmd_t;

endpackage

>>> rtl/core/pbm_front.sv
module pbm_front
    import pbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_value,
    input  logic       stream_end,
    input  logic       fifo_full,
    output logic       push,
    output pbm_cmd_t   push_cmd
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  magic_first_reg, magic_first_next;
    logic [7:0]  magic_second_reg, magic_second_next;
    logic [1:0]  token_length_reg, token_length_next;
    num_t        num_reg, num_next;
    logic [12:0] width_reg, width_next;
    logic [12:0] height_reg, height_next;
    logic [11:0] col_reg, col_next;
    logic [11:0] row_reg, row_next;

    logic        accept;
    logic        ws;
    logic        bad_magic;
    num_t        num_taken;
    num_t        num_first;
    err_code_t   num_err;
    logic [12:0] left;
    logic [3:0]  n;
    logic        row_ends;
    logic        last_row;

    // Adds one byte of a size token to the running value.
    function automatic num_t take_char(num_t cur, logic [7:0] b);
        num_t        r;
        logic [15:0] v;
        r = cur;
        v = {cur.value, 3'b000} + {2'b00, cur.value, 1'b0} + {12'd0, b[3:0]};
        if (cur.status == NS_NONE || cur.status == NS_DIGITS) begin
            if (b >= 8'd48 && b <= 8'd57) begin
                if (v > 16'(MAX_DIM)) begin
                    r.status = NS_OVER;
                end
                else begin
                    r.value  = v[12:0];
                    r.status = NS_DIGITS;
                end
            end
            else begin
                r.status = (cur.status == NS_DIGITS) ? NS_DONE : NS_NODIG;
            end
        end
        return r;
    endfunction

    // Halted input is taken and dropped; otherwise wait for queue room.
    assign in_ready = (phase_reg == PH_HALT) || !fifo_full;
    assign accept   = in_valid && in_ready;

    assign ws = (byte_value >= 8'd9 && byte_value <= 8'd13) || byte_value == 8'd32;
    assign bad_magic = token_length_reg != 2'd2 || magic_second_reg != 8'd52 ||
                       (magic_first_reg != 8'd80 && magic_first_reg != 8'd112);

    assign num_taken = take_char(num_reg, byte_value);
    assign num_first = take_char('{status: NS_NONE, value: 13'd0}, byte_value);

    // Verdict on a finished size token.
    always_comb
    begin
        if (num_reg.status == NS_NONE || num_reg.status == NS_NODIG) begin
            num_err = ERR_BAD_NUMBER;
        end
        else if (num_reg.status == NS_OVER || num_reg.value == 13'd0) begin
            num_err = ERR_RANGE;
        end
        else begin
            num_err = ERR_NONE;
        end
    end

    // Pixels left in the current row and what this byte covers.
    assign left     = (width_reg > {1'b0, col_reg}) ? width_reg - {1'b0, col_reg} : 13'd0;
    assign n        = (left < 13'd8) ? left[3:0] : 4'd8;
    assign row_ends = ({1'b0, col_reg} + 13'(n)) >= width_reg;
    assign last_row = ({1'b0, row_reg} + 13'd1) >= height_reg;

    // Header parser and data byte classification.
    always_comb
    begin
        phase_next        = phase_reg;
        magic_first_next  = magic_first_reg;
        magic_second_next = magic_second_reg;
        token_length_next = token_length_reg;
        num_next          = num_reg;
        width_next        = width_reg;
        height_next       = height_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        push              = 1'b0;
        push_cmd          = '{op: KIND_ERROR, data: byte_value, col: col_reg,
                              row: row_reg, count: 4'd1, done: 1'b0, wd: 13'd0,
                              ht: 13'd0, err: ERR_NONE};
        if (accept && phase_reg != PH_HALT) begin
            if (stream_end) begin
                push         = 1'b1;
                push_cmd.err = ERR_EARLY_END;
                phase_next   = PH_HALT;
            end
            else begin
                unique case (phase_reg)
                    PH_MAGIC_WAIT:
                    begin
                        if (ws) begin
                            push         = 1'b1;
                            push_cmd.err = ERR_LEAD_SPACE;
                            phase_next   = PH_HALT;
                        end
                        else begin
                            magic_first_next  = byte_value;
                            token_length_next = 2'd1;
                            phase_next        = PH_MAGIC;
                        end
                    end
                    PH_MAGIC:
                    begin
                        if (!ws) begin
                            if (token_length_reg == 2'd1) begin
                                magic_second_next = byte_value;
                                token_length_next = 2'd2;
                            end
                            else begin
                                token_length_next = 2'd3;
                            end
                        end
                        else if (bad_magic) begin
                            push         = 1'b1;
                            push_cmd.err = ERR_BAD_MAGIC;
                            phase_next   = PH_HALT;
                        end
                        else begin
                            phase_next = PH_W_WAIT;
                        end
                    end
                    PH_W_WAIT, PH_H_WAIT:
                    begin
                        if (!ws) begin
                            num_next   = num_first;
                            phase_next = (phase_reg == PH_W_WAIT) ? PH_W : PH_H;
                        end
                    end
                    PH_W, PH_H:
                    begin
                        if (!ws) begin
                            num_next = num_taken;
                        end
                        else if (num_err != ERR_NONE) begin
                            push         = 1'b1;
                            push_cmd.err = num_err;
                            phase_next   = PH_HALT;
                        end
                        else if (phase_reg == PH_W) begin
                            width_next = num_reg.value;
                            num_next   = '{status: NS_NONE, value: 13'd0};
                            phase_next = PH_H_WAIT;
                        end
                        else begin
                            height_next  = num_reg.value;
                            num_next     = '{status: NS_NONE, value: 13'd0};
                            col_next     = 12'd0;
                            row_next     = 12'd0;
                            phase_next   = PH_DATA;
                            push         = 1'b1;
                            push_cmd.op  = KIND_HEADER;
                            push_cmd.wd  = width_reg;
                            push_cmd.ht  = num_reg.value;
                        end
                    end
                    PH_DATA:
                    begin
                        if (n == 4'd0) begin
                            phase_next = PH_HALT;
                        end
                        else begin
                            push           = 1'b1;
                            push_cmd.op    = KIND_PIXEL;
                            push_cmd.count = n;
                            push_cmd.done  = row_ends && last_row;
                            if (row_ends) begin
                                col_next = 12'd0;
                                if (last_row) begin
                                    phase_next = PH_HALT;
                                end
                                else begin
                                    row_next = row_reg + 12'd1;
                                end
                            end
                            else begin
                                col_next = col_reg + 12'(n);
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HALT;
                    end
                endcase
            end
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg        <= PH_MAGIC_WAIT;
            magic_first_reg  <= 8'd0;
            magic_second_reg <= 8'd0;
            token_length_reg <= 2'd0;
            num_reg          <= '{status: NS_NONE, value: 13'd0};
            width_reg        <= 13'd0;
            height_reg       <= 13'd0;
            col_reg          <= 12'd0;
            row_reg          <= 12'd0;
        end
        else begin
            phase_reg        <= phase_next;
            magic_first_reg  <= magic_first_next;
            magic_second_reg <= magic_second_next;
            token_length_reg <= token_length_next;
            num_reg          <= num_next;
            width_reg        <= width_next;
            height_reg       <= height_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
        end
    end

endmodule

>>> rtl/core/pbm_cmd_fifo.sv
module pbm_cmd_fifo
    import pbm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  pbm_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output pbm_cmd_t head_cmd
);

    pbm_cmd_t             entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg, count_next;

    assign full       = count_reg == FIFO_CW'(FIFO_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // Occupancy follows push and pop.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("command popped from an empty queue");

endmodule

>>> rtl/core/pbm_back.sv
module pbm_back
    import pbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  pbm_cmd_t    cmd,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic        pixel,
    output logic [11:0] column,
    output logic [11:0] row,
    output logic [12:0] width,
    output logic [12:0] height,
    output logic [2:0]  error_code,
    output logic        last,
    output logic        image_done
);

    logic        out_valid_reg;
    logic [2:0]  idx_reg;
    kind_t       kind_reg;
    logic        pixel_reg;
    logic [11:0] column_reg;
    logic [11:0] row_reg;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    err_code_t   err_reg;
    logic        last_reg;
    logic        done_reg;

    logic        load;
    logic        elem_last;
    logic        is_pixel;

    // A new beat enters the output register when it is empty or being taken.
    assign load      = cmd_valid && (!out_valid_reg || out_ready);
    assign elem_last = ({1'b0, idx_reg} + 4'd1) == cmd.count;
    assign pop       = load && elem_last;
    assign is_pixel  = cmd.op == KIND_PIXEL;

    // Beat index within the current command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else begin
            if (load) begin
                out_valid_reg <= 1'b1;
                idx_reg       <= elem_last ? 3'd0 : idx_reg + 3'd1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load) begin
            kind_reg   <= cmd.op;
            pixel_reg  <= is_pixel ? cmd.data[3'd7 - idx_reg] : 1'b0;
            column_reg <= is_pixel ? cmd.col + 12'(idx_reg) : 12'd0;
            row_reg    <= is_pixel ? cmd.row : 12'd0;
            width_reg  <= cmd.wd;
            height_reg <= cmd.ht;
            err_reg    <= cmd.err;
            last_reg   <= elem_last;
            done_reg   <= elem_last && cmd.done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign pixel      = pixel_reg;
    assign column     = column_reg;
    assign row        = row_reg;
    assign width      = width_reg;
    assign height     = height_reg;
    assign error_code = err_reg;
    assign last       = last_reg;
    assign image_done = done_reg;

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> ({1'b0, idx_reg} < cmd.count))
        else $error("beat index past command length");

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !is_pixel) |-> pop)
        else $error("header or error command spans more than one beat");

endmodule

>>> rtl/core/pbm_p4_stream_decoder.sv
// The first result of a byte is registered twice: into the command queue when the byte is
// accepted, then into the output register when the queue head is loaded.
// One result beat per cycle while commands are queued and out_ready holds; the expander
// sends one pixel of a data byte (up to 8) per beat.
// Header bytes are taken one per cycle; input stalls only while the 4-entry queue is full.
// Reset (rst_n, asynchronous): parser awaits the magic token and the queue is empty.
module pbm_p4_stream_decoder
    import pbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_value,
    input  logic        stream_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic        pixel,
    output logic [11:0] column,
    output logic [11:0] row,
    output logic [12:0] width,
    output logic [12:0] height,
    output logic [2:0]  error_code,
    output logic        last,
    output logic        image_done
);

    logic     fifo_full;
    logic     push;
    pbm_cmd_t push_cmd;
    logic     pop;
    logic     head_valid;
    pbm_cmd_t head_cmd;

    // Header parser and byte classifier.
    pbm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_value (byte_value),
        .stream_end (stream_end),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // Command queue.
    pbm_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Pixel expander and output register.
    pbm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (head_valid),
        .cmd        (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .pixel      (pixel),
        .column     (column),
        .row        (row),
        .width      (width),
        .height     (height),
        .error_code (error_code),
        .last       (last),
        .image_done (image_done)
    );

endmodule

>>> tb/sv/pbm_checker.sv
module pbm_checker
    import pbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  byte_value,
    input  logic        stream_end,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  kind,
    input  logic        pixel,
    input  logic [11:0] column,
    input  logic [11:0] row,
    input  logic [12:0] width,
    input  logic [12:0] height,
    input  logic [2:0]  error_code,
    input  logic        last,
    input  logic        image_done,
    output int          fail_count,
    output int          pending_count,
    output int          checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // One predicted result beat.
    typedef struct packed {
        kind_t       kind;
        logic        pix;
        logic [11:0] col;
        logic [11:0] rowi;
        logic [12:0] wd;
        logic [12:0] ht;
        err_code_t   err;
        logic        lst;
        logic        done;
    } decoded_t;

    decoded_t    decoded_q[$];

    // Shadow copy of the decoder state.
    phase_t      parse_phase;
    logic [7:0]  magic_hi;
    logic [7:0]  magic_lo;
    logic [1:0]  magic_len;
    int unsigned num_value;
    num_status_t num_status;
    logic [12:0] img_w;
    logic [12:0] img_h;
    logic [11:0] col_pos;
    logic [11:0] row_pos;

    function automatic logic is_blank(input logic [7:0] b);
        return (b >= 8'd9 && b <= 8'd13) || b == " ";
    endfunction

    task automatic queue_result(input kind_t k, input logic p, input logic [11:0] c,
                                input logic [11:0] r, input logic [12:0] w,
                                input logic [12:0] h, input err_code_t e,
                                input logic l, input logic d);
        decoded_t item;
        item = '{k, p, c, r, w, h, e, l, d};
        decoded_q.push_back(item);
    endtask

    // Every error is a single beat, and the decoder stops for good.
    task automatic halt_with(input err_code_t e);
        parse_phase = PH_HALT;
        queue_result(KIND_ERROR, 1'b0, '0, '0, '0, '0, e, 1'b1, 1'b0);
    endtask

    // Digits accumulate until the first non-digit; past MAX_DIM the value freezes.
    task automatic take_digit_char(input logic [7:0] b);
        int unsigned v;
        if (num_status == NS_NONE || num_status == NS_DIGITS) begin
            if (b >= "0" && b <= "9") begin
                v = num_value * 10 + (b - "0");
                if (v > MAX_DIM) begin
                    num_status = NS_OVER;
                end
                else begin
                    num_value  = v;
                    num_status = NS_DIGITS;
                end
            end
            else begin
                num_status = (num_status == NS_DIGITS) ? NS_DONE : NS_NODIG;
            end
        end
    endtask

    function automatic err_code_t size_fault();
        if (num_status == NS_NONE || num_status == NS_NODIG)
            return ERR_BAD_NUMBER;
        if (num_status == NS_OVER || num_value == 0)
            return ERR_RANGE;
        return ERR_NONE;
    endfunction

    // Advance the shadow state by one accepted byte and queue what it yields.
    task automatic decode_byte(input logic [7:0] b, input logic e);
        logic        blank;
        err_code_t   fault;
        int unsigned left;
        int unsigned n;
        logic        final_row;
        logic        row_ends;
        blank = is_blank(b);
        if (parse_phase == PH_HALT)
            return;
        if (e) begin
            halt_with(ERR_EARLY_END);
            return;
        end
        case (parse_phase)
            PH_MAGIC_WAIT:
            begin
                if (blank) begin
                    halt_with(ERR_LEAD_SPACE);
                end
                else begin
                    magic_hi    = b;
                    magic_len   = 2'd1;
                    parse_phase = PH_MAGIC;
                end
            end
            PH_MAGIC:
            begin
                if (!blank) begin
                    if (magic_len == 2'd1) begin
                        magic_lo  = b;
                        magic_len = 2'd2;
                    end
                    else begin
                        magic_len = 2'd3;
                    end
                end
                else if (magic_len != 2'd2 || magic_lo != "4" ||
                         (magic_hi != "P" && magic_hi != "p")) begin
                    halt_with(ERR_BAD_MAGIC);
                end
                else begin
                    parse_phase = PH_W_WAIT;
                end
            end
            PH_W_WAIT, PH_H_WAIT:
            begin
                if (!blank) begin
                    num_value  = 0;
                    num_status = NS_NONE;
                    take_digit_char(b);
                    parse_phase = phase_t'(parse_phase + 3'd1);
                end
            end
            PH_W, PH_H:
            begin
                if (!blank) begin
                    take_digit_char(b);
                end
                else begin
                    fault = size_fault();
                    if (fault != ERR_NONE) begin
                        halt_with(fault);
                    end
                    else begin
                        if (parse_phase == PH_W) begin
                            img_w       = num_value[12:0];
                            parse_phase = PH_H_WAIT;
                        end
                        else begin
                            img_h       = num_value[12:0];
                            col_pos     = '0;
                            row_pos     = '0;
                            parse_phase = PH_DATA;
                            queue_result(KIND_HEADER, 1'b0, '0, '0, img_w, img_h,
                                         ERR_NONE, 1'b1, 1'b0);
                        end
                        num_value  = 0;
                        num_status = NS_NONE;
                    end
                end
            end
            default:
            begin
                // Data byte: MSB first, padding bits past the row width dropped.
                left      = (img_w > {1'b0, col_pos}) ? 32'(img_w - {1'b0, col_pos}) : 0;
                n         = (left < 8) ? left : 8;
                final_row = (row_pos + 1 >= img_h);
                if (n == 0) begin
                    parse_phase = PH_HALT;
                    return;
                end
                row_ends = (col_pos + n >= img_w);
                for (int i = 0; i < n; i++) begin
                    queue_result(KIND_PIXEL, b[7 - i], 12'(col_pos + i), row_pos, '0, '0,
                                 ERR_NONE, i + 1 == n, (i + 1 == n) && row_ends && final_row);
                end
                if (row_ends) begin
                    col_pos = '0;
                    if (final_row)
                        parse_phase = PH_HALT;
                    else
                        row_pos = row_pos + 12'd1;
                end
                else begin
                    col_pos = 12'(col_pos + n);
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [12:0] want,
                               input logic [12:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Predict on every accepted input beat, compare every accepted output beat.
    always @(posedge clk) begin : watch
        decoded_t want;
        if (!rst_n) begin
            parse_phase   = PH_MAGIC_WAIT;
            magic_hi      = '0;
            magic_lo      = '0;
            magic_len     = '0;
            num_value     = 0;
            num_status    = NS_NONE;
            img_w         = '0;
            img_h         = '0;
            col_pos       = '0;
            row_pos       = '0;
            fail_count    = 0;
            checked_count = 0;
            decoded_q.delete();
        end
        else begin
            if (in_valid && in_ready)
                decode_byte(byte_value, stream_end);
            if (out_valid && out_ready) begin
                checked_count++;
                if (decoded_q.size() == 0) begin
                    $error("result beat with nothing predicted: kind %0d", kind);
                    fail_count++;
                end
                else begin
                    want = decoded_q.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("pixel", want.pix, pixel);
                    check_field("column", want.col, column);
                    check_field("row", want.rowi, row);
                    check_field("width", want.wd, width);
                    check_field("height", want.ht, height);
                    check_field("error_code", want.err, error_code);
                    check_field("last", want.lst, last);
                    check_field("image_done", want.done, image_done);
                end
            end
        end
        pending_count = decoded_q.size();
    end

endmodule

>>> tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pbm_pkg::*;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [7:0]  byte_value = '0;
    logic        stream_end = 1'b0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [1:0]  kind;
    logic        pixel;
    logic [11:0] column;
    logic [11:0] row;
    logic [12:0] width;
    logic [12:0] height;
    logic [2:0]  error_code;
    logic        last;
    logic        image_done;
    int          fail_count;
    int          pending_count;
    int          checked_count;

    // While set, neither side idles.
    logic        calm = 1'b0;

    logic [7:0]  file_bytes[$];
    logic        end_flags[$];

    pbm_p4_stream_decoder dut (.*);
    pbm_checker u_checker (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stalls about one cycle in five.
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= 19);

    initial begin
        #1000000;
        $display("Timed out with %0d results still predicted.", pending_count);
        $display("Test completed with failures");
        $finish;
    end

    task automatic append_beat(input logic [7:0] b, input logic e);
        file_bytes.push_back(b);
        end_flags.push_back(e);
    endtask

    task automatic append_blanks(input int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 5);
            append_beat((pick == 5) ? 8'd32 : 8'(9 + pick), 1'b0);
        end
    endtask

    // Size token: optional leading zeros, the digits, optional ignored tail.
    task automatic append_size(input int v);
        string digits;
        string junk;
        digits = $sformatf("%0d", v);
        junk   = "x+-#;";
        repeat ($urandom_range(0, 2))
            append_beat("0", 1'b0);
        for (int i = 0; i < digits.len(); i++)
            append_beat(digits[i], 1'b0);
        repeat ($urandom_range(0, 2))
            append_beat(junk[$urandom_range(0, junk.len() - 1)], 1'b0);
    endtask

    // Present one beat and hold it until accepted.
    task automatic send_beat(input logic [7:0] b, input logic e);
        while (!calm && $urandom_range(0, 99) < 19) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        byte_value <= b;
        stream_end <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    initial begin : stimulus
        logic [7:0] directed[6];
        int         img_w;
        int         img_h;
        int         row_bytes;
        int         total;
        int         data_count;
        int         header_len;
        logic       early;
        logic       lower_magic;

        directed = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h80, 8'h01};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Header: magic, blank runs, width and height, one closing blank.
        lower_magic = $urandom_range(0, 1);
        img_w       = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40)
                                                   : $urandom_range(1, 8);
        row_bytes   = (img_w + 7) / 8;
        img_h       = 160 / row_bytes;
        total       = img_h * row_bytes;
        early       = ($urandom_range(0, 3) == 0);
        data_count  = early ? $urandom_range(total - 20, total - 1) : total;

        append_beat(lower_magic ? "p" : "P", 1'b0);
        append_beat("4", 1'b0);
        append_blanks($urandom_range(1, 3));
        append_size(img_w);
        append_blanks($urandom_range(1, 3));
        append_size(img_h);
        append_blanks(1);
        header_len = file_bytes.size();

        // Data: a few fixed patterns, then random bytes.
        for (int i = 0; i < data_count; i++)
            append_beat((i < 6) ? directed[i] : 8'($urandom_range(0, 255)), 1'b0);

        // End of file, either early or on a block already halted.
        if (!early) begin
            append_beat(8'($urandom_range(0, 255)), 1'b0);
            append_beat(8'($urandom_range(0, 255)), 1'b0);
        end
        append_beat(8'($urandom_range(0, 255)), 1'b1);

        for (int i = 0; i < file_bytes.size(); i++) begin
            calm = (i >= header_len + 40 && i < header_len + 90);
            send_beat(file_bytes[i], end_flags[i]);
            if (i == header_len - 1 || i == header_len + 100)
                wait_for_drain();
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);

        $display("Fed %0d beats: %s header with a %0dx%0d image, %0d data bytes, %s.",
                 file_bytes.size(), lower_magic ? "p4" : "P4", img_w, img_h,
                 data_count, early ? "cut short by end of stream" : "image completed");
        $display("Checked %0d result beats, %0d mismatches.", checked_count, fail_count);
        if (fail_count == 0 && pending_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
